### rtl/sdt_pkg.sv
// Shared widths, register indexes and pipeline types for the stereo triangulation unit.
package sdt_pkg;

	localparam int unsigned PIX_W   = 16;
	localparam int unsigned BASE_W  = 20;
	localparam int unsigned CFG_W   = 20;
	localparam int unsigned OUT_W   = 32;
	localparam int unsigned QUO_W   = 33;
	localparam int unsigned DEN_W   = 33;
	localparam int unsigned NUM_W   = 54;
	localparam int unsigned LANES   = 3;

	typedef enum logic [2:0] {
		REG_FOCAL_X  = 3'd0,
		REG_FOCAL_Y  = 3'd1,
		REG_CENTER_X = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_BASELINE = 3'd4
	} cfg_reg_t;

	localparam int unsigned LANE_Z = 0;
	localparam int unsigned LANE_X = 1;
	localparam int unsigned LANE_Y = 2;

	// one division lane as it moves down the pipeline
	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             zero;
		logic             ovf;
	} div_lane_t;

	typedef div_lane_t [LANES-1:0] div_item_t;

endpackage

### rtl/stereo_disparity_triangulation_unit.sv
// From input transfer to result: 3 setup stages, 33 divide stages, and an output
// register fed by the rounding/saturation logic. Throughput: one point per cycle
// when not stalled; three restoring dividers, one quotient bit per stage.
// The pipeline advances as a whole while the output register is empty or being taken.
// Reset clears all valid bits and loads the default camera calibration.
module stereo_disparity_triangulation_unit
	import sdt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     u_left,
	input  logic [PIX_W-1:0]     u_right,
	input  logic [PIX_W-1:0]     v_row,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [OUT_W-1:0] pos_x,
	output logic signed [OUT_W-1:0] pos_y,
	output logic signed [OUT_W-1:0] pos_z,
	output logic                 point_valid
);

	logic [PIX_W-1:0]  focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [BASE_W-1:0] baseline_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= 16'd11200;
			focal_y_q  <= 16'd11200;
			center_x_q <= 16'd5120;
			center_y_q <= 16'd3840;
			baseline_q <= 20'd7864;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FOCAL_X:  focal_x_q  <= cfg_data[PIX_W-1:0];
				REG_FOCAL_Y:  focal_y_q  <= cfg_data[PIX_W-1:0];
				REG_CENTER_X: center_x_q <= cfg_data[PIX_W-1:0];
				REG_CENTER_Y: center_y_q <= cfg_data[PIX_W-1:0];
				REG_BASELINE: baseline_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: differences and first products
	logic signed [PIX_W:0] d_c, du_c, dv_c;
	logic [PIX_W-1:0]      dabs_c, duabs_c, dvabs_c;
	assign d_c     = $signed({1'b0, u_left}) - $signed({1'b0, u_right});
	assign du_c    = $signed({1'b0, u_left}) - $signed({1'b0, center_x_q});
	assign dv_c    = $signed({1'b0, v_row}) - $signed({1'b0, center_y_q});
	assign dabs_c  = d_c[PIX_W]  ? PIX_W'(-d_c)  : d_c[PIX_W-1:0];
	assign duabs_c = du_c[PIX_W] ? PIX_W'(-du_c) : du_c[PIX_W-1:0];
	assign dvabs_c = dv_c[PIX_W] ? PIX_W'(-dv_c) : dv_c[PIX_W-1:0];

	logic                     v_s1, v_s2, v_s3;
	logic                     dneg_s1, duneg_s1, dvneg_s1, dzero_s1, fx0_s1, fy0_s1;
	logic [PIX_W-1:0]         dabs_s1, dvabs_s1;
	logic [BASE_W+PIX_W-1:0]  bfx_s1, bdu_s1;
	logic [2*PIX_W-1:0]       dfy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dneg_s1  <= d_c[PIX_W];
			duneg_s1 <= du_c[PIX_W];
			dvneg_s1 <= dv_c[PIX_W];
			dzero_s1 <= (d_c == '0);
			fx0_s1   <= (focal_x_q == '0);
			fy0_s1   <= (focal_y_q == '0);
			dabs_s1  <= dabs_c;
			dvabs_s1 <= dvabs_c;
			bfx_s1   <= baseline_q * focal_x_q;
			bdu_s1   <= baseline_q * duabs_c;
			dfy_s1   <= dabs_c * focal_y_q;
		end
	end

	// stage 2: numerator of y
	logic                          dneg_s2, duneg_s2, dvneg_s2, dzero_s2, fx0_s2, fy0_s2;
	logic [PIX_W-1:0]              dabs_s2;
	logic [BASE_W+PIX_W-1:0]       bfx_s2, bdu_s2;
	logic [BASE_W+2*PIX_W-1:0]     ny_s2;
	logic [2*PIX_W-1:0]            dfy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dneg_s2  <= dneg_s1;
			duneg_s2 <= duneg_s1;
			dvneg_s2 <= dvneg_s1;
			dzero_s2 <= dzero_s1;
			fx0_s2   <= fx0_s1;
			fy0_s2   <= fy0_s1;
			dabs_s2  <= dabs_s1;
			bfx_s2   <= bfx_s1;
			bdu_s2   <= bdu_s1;
			dfy_s2   <= dfy_s1;
			ny_s2    <= bfx_s1 * dvabs_s1;
		end
	end

	// stage 3: rounding numerator 2n+den over divisor 2den, overflow precheck
	div_item_t item_c;
	logic [NUM_W-1:0] num_c [LANES];
	logic [DEN_W-1:0] dv2_c [LANES];
	logic [DEN_W-2:0] den_c [LANES];
	logic             neg_c [LANES];
	logic             zero_c[LANES];

	always_comb begin
		num_c[LANE_Z]  = NUM_W'({bfx_s2, 1'b0}) + NUM_W'(dabs_s2);
		num_c[LANE_X]  = NUM_W'({bdu_s2, 1'b0}) + NUM_W'(dabs_s2);
		num_c[LANE_Y]  = NUM_W'({ny_s2, 1'b0}) + NUM_W'(dfy_s2);
		den_c[LANE_Z]  = (DEN_W-1)'(dabs_s2);
		den_c[LANE_X]  = (DEN_W-1)'(dabs_s2);
		den_c[LANE_Y]  = dfy_s2;
		neg_c[LANE_Z]  = dneg_s2;
		neg_c[LANE_X]  = dneg_s2 ^ duneg_s2;
		neg_c[LANE_Y]  = dneg_s2 ^ dvneg_s2;
		zero_c[LANE_Z] = dzero_s2 || fx0_s2;
		zero_c[LANE_X] = dzero_s2 || fx0_s2;
		zero_c[LANE_Y] = dzero_s2 || fy0_s2;
		for (int l = 0; l < LANES; l++) begin
			dv2_c[l]       = {den_c[l], 1'b0};
			item_c[l].rem  = num_c[l];
			item_c[l].den  = dv2_c[l];
			item_c[l].quo  = '0;
			item_c[l].neg  = neg_c[l];
			item_c[l].zero = zero_c[l];
			item_c[l].ovf  = ({12'd0, num_c[l]} >= ({33'd0, dv2_c[l]} << QUO_W));
		end
	end

	logic      pv_s3;
	div_item_t div_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s3 <= item_c;
			pv_s3  <= !dzero_s2;
		end
	end

	// divide stages: one quotient bit per stage, MSB first
	div_item_t stage_sd [QUO_W+1];
	logic      stage_v_sd [QUO_W+1];
	logic      stage_pv_sd [QUO_W+1];

	assign stage_sd[0]    = div_s3;
	assign stage_v_sd[0]  = v_s3;
	assign stage_pv_sd[0] = pv_s3;

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		localparam int unsigned BIT = QUO_W - 1 - k;
		div_item_t nxt;

		always_comb begin
			logic [65:0] sh;
			logic [65:0] rw;
			nxt = stage_sd[k];
			for (int l = 0; l < LANES; l++) begin
				sh = {33'd0, stage_sd[k][l].den} << BIT;
				rw = {12'd0, stage_sd[k][l].rem};
				if (rw >= sh) begin
					nxt[l].rem      = NUM_W'(rw - sh);
					nxt[l].quo[BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) stage_v_sd[k+1] <= 1'b0;
			else if (adv) stage_v_sd[k+1] <= stage_v_sd[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stage_sd[k+1]    <= nxt;
				stage_pv_sd[k+1] <= stage_pv_sd[k];
			end
		end
	end

	// saturate, apply sign and zero cases
	logic [OUT_W-1:0] res_c [LANES];

	always_comb begin
		logic [QUO_W-1:0] lim;
		logic [QUO_W-1:0] mag;
		for (int l = 0; l < LANES; l++) begin
			lim = stage_sd[QUO_W][l].neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
			mag = stage_sd[QUO_W][l].quo;
			if (stage_sd[QUO_W][l].ovf || mag > lim) mag = lim;
			if (stage_sd[QUO_W][l].zero) res_c[l] = '0;
			else if (stage_sd[QUO_W][l].neg) res_c[l] = OUT_W'(-mag);
			else res_c[l] = mag[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= stage_v_sd[QUO_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_z       <= res_c[LANE_Z];
			pos_x       <= res_c[LANE_X];
			pos_y       <= res_c[LANE_Y];
			point_valid <= stage_pv_sd[QUO_W];
		end
	end

endmodule

### rtl/sdt_checker.sv
// Port-level checks for the stereo triangulation unit, bound to the top level.
module sdt_port_props
	import sdt_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [OUT_W-1:0]     pos_x,
	input logic [OUT_W-1:0]     pos_y,
	input logic [OUT_W-1:0]     pos_z,
	input logic                 point_valid
);

	// a point with no disparity carries no coordinates
	a_zero_disp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> pos_x == '0 && pos_y == '0 && pos_z == '0)
		else $error("invalid point with nonzero coordinates");

	// empty output register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output empty");

	// a result being taken frees the input in the same cycle
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input stalled during output transfer");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_z) && $stable(point_valid))
		else $error("stalled result changed");

endmodule

bind stereo_disparity_triangulation_unit sdt_port_props u_sdt_checker (.*);
